@@ design/bcrm_pkg.sv @@
// ----------------------------------------------------------------------------
// bcrm_pkg
// Shared types and constants for the box corner running median filter.
// ----------------------------------------------------------------------------
package bcrm_pkg;

    localparam int WINDOW_DEPTH_DEF = 8;
    localparam int POS_W  = 13;
    localparam int SIZE_W = 12;
    localparam int VAL_W  = 14;
    localparam int OUT_W  = 15;
    localparam int NUM_Q  = 4;
    localparam int BIT_CNT_W = 4;

    localparam logic [1:0] Q_LEFT   = 2'd0;
    localparam logic [1:0] Q_RIGHT  = 2'd1;
    localparam logic [1:0] Q_TOP    = 2'd2;
    localparam logic [1:0] Q_BOTTOM = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RUN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic start;
        logic step;
    } sel_ctrl_t;

endpackage

@@ design/bcrm_select.sv @@
// ----------------------------------------------------------------------------
// bcrm_select
// Bit-serial rank select: finds the value of a given rank, MSB first.
// ----------------------------------------------------------------------------
module bcrm_select #(
    parameter int WINDOW_DEPTH = bcrm_pkg::WINDOW_DEPTH_DEF,
    parameter int CNT_W        = $clog2(WINDOW_DEPTH + 1)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bcrm_pkg::sel_ctrl_t           ctrl,
    input  logic [CNT_W-1:0]              rank_init,
    input  logic [WINDOW_DEPTH-1:0]       valid_mask,
    input  logic [WINDOW_DEPTH-1:0]       bits,
    output logic [bcrm_pkg::VAL_W-1:0]    result
);

    logic [WINDOW_DEPTH-1:0]    active_reg;
    logic [CNT_W-1:0]           rank_reg;
    logic [bcrm_pkg::VAL_W-1:0] res_reg;
    logic [WINDOW_DEPTH-1:0]    zeros;
    logic [CNT_W-1:0]           zero_cnt;

    assign zeros = active_reg & ~bits;

    always_comb begin
        zero_cnt = '0;
        for (int k = 0; k < WINDOW_DEPTH; k++) begin
            zero_cnt = zero_cnt + CNT_W'(zeros[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= '0;
            rank_reg   <= '0;
        end else if (ctrl.start) begin
            active_reg <= valid_mask;
            rank_reg   <= rank_init;
        end else if (ctrl.step) begin
            if (rank_reg < zero_cnt) begin
                active_reg <= zeros;
            end else begin
                active_reg <= active_reg & bits;
                rank_reg   <= rank_reg - zero_cnt;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.step) begin
            res_reg <= {res_reg[bcrm_pkg::VAL_W-2:0], ~(rank_reg < zero_cnt)};
        end
    end

    assign result = res_reg;

endmodule

@@ design/box_corner_running_median.sv @@
// ----------------------------------------------------------------------------
// box_corner_running_median
// Running median of box corners over a window of the last found boxes.
// ----------------------------------------------------------------------------
// channel   dir  handshake          payload
// s_        in   s_valid/s_ready    box_found, box_left, box_top, box_width,
//                                   box_height
// m_        out  m_valid/m_ready    bl/br/tr/tl col and row, half pixels
//
// A request without a box is taken and gives no result.
// A request with a box passes a load state, a bit-serial select over the
// 14 value bits, MSB first, and a finish state that posts the result.
// The result register holds while m_ready is low; the next request is taken
// once the result is posted. Reset empties the window.
// ----------------------------------------------------------------------------
module box_corner_running_median #(
    parameter int WINDOW_DEPTH = bcrm_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_box_found,
    input  logic signed [bcrm_pkg::POS_W-1:0]  s_box_left,
    input  logic signed [bcrm_pkg::POS_W-1:0]  s_box_top,
    input  logic [bcrm_pkg::SIZE_W-1:0]        s_box_width,
    input  logic [bcrm_pkg::SIZE_W-1:0]        s_box_height,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [bcrm_pkg::OUT_W-1:0]  m_bl_col,
    output logic signed [bcrm_pkg::OUT_W-1:0]  m_bl_row,
    output logic signed [bcrm_pkg::OUT_W-1:0]  m_br_col,
    output logic signed [bcrm_pkg::OUT_W-1:0]  m_br_row,
    output logic signed [bcrm_pkg::OUT_W-1:0]  m_tr_col,
    output logic signed [bcrm_pkg::OUT_W-1:0]  m_tr_row,
    output logic signed [bcrm_pkg::OUT_W-1:0]  m_tl_col,
    output logic signed [bcrm_pkg::OUT_W-1:0]  m_tl_row
);

    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int VW    = bcrm_pkg::VAL_W;
    localparam int NQ    = bcrm_pkg::NUM_Q;
    localparam logic [VW-1:0] SIGN_FLIP = {1'b1, {(VW-1){1'b0}}};

    bcrm_pkg::state_t state_reg, state_next;

    logic [VW-1:0]        store_reg [NQ][WINDOW_DEPTH];
    logic [VW-1:0]        work_reg  [NQ][WINDOW_DEPTH];
    logic [CNT_W-1:0]     fill_reg, fill_next;
    logic [IDX_W-1:0]     oldest_reg, oldest_next;
    logic [IDX_W-1:0]     slot;
    logic [WINDOW_DEPTH-1:0] valid_mask;
    logic [bcrm_pkg::BIT_CNT_W-1:0] bit_reg, bit_next;
    logic                 accept, write_en;
    logic [VW-1:0]        new_val [NQ];
    logic [CNT_W-1:0]     rank_lo, rank_hi;
    bcrm_pkg::sel_ctrl_t  ctrl;
    logic [VW-1:0]        sel_lo [NQ];
    logic [VW-1:0]        sel_hi [NQ];
    logic signed [bcrm_pkg::OUT_W-1:0] med [NQ];
    logic                 m_valid_reg, post;
    logic signed [bcrm_pkg::OUT_W-1:0] out_reg [NQ];

    assign accept   = s_valid && s_ready;
    assign write_en = accept && s_box_found;
    assign slot     = (fill_reg < CNT_W'(WINDOW_DEPTH)) ? fill_reg[IDX_W-1:0] : oldest_reg;

    always_comb begin
        logic [VW-1:0] x, y;
        x = VW'(s_box_left);
        y = VW'(s_box_top);
        new_val[bcrm_pkg::Q_LEFT]   = x ^ SIGN_FLIP;
        new_val[bcrm_pkg::Q_RIGHT]  = (x + VW'(s_box_width)) ^ SIGN_FLIP;
        new_val[bcrm_pkg::Q_TOP]    = y ^ SIGN_FLIP;
        new_val[bcrm_pkg::Q_BOTTOM] = (y + VW'(s_box_height)) ^ SIGN_FLIP;
    end

    always_comb begin
        fill_next   = fill_reg;
        oldest_next = oldest_reg;
        if (write_en) begin
            if (fill_reg < CNT_W'(WINDOW_DEPTH)) begin
                fill_next = fill_reg + CNT_W'(1);
            end else if (oldest_reg == IDX_W'(WINDOW_DEPTH - 1)) begin
                oldest_next = '0;
            end else begin
                oldest_next = oldest_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg   <= '0;
            oldest_reg <= '0;
        end else begin
            fill_reg   <= fill_next;
            oldest_reg <= oldest_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (write_en) begin
            for (int q = 0; q < NQ; q++) begin
                store_reg[q][slot] <= new_val[q];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bcrm_pkg::ST_IDLE;
            bit_reg   <= '0;
        end else begin
            state_reg <= state_next;
            bit_reg   <= bit_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        bit_next   = bit_reg;
        s_ready    = 1'b0;
        ctrl       = '0;
        post       = 1'b0;
        unique case (state_reg)
            bcrm_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid && s_box_found) begin
                    state_next = bcrm_pkg::ST_LOAD;
                end
            end
            bcrm_pkg::ST_LOAD: begin
                ctrl.start = 1'b1;
                bit_next   = '0;
                state_next = bcrm_pkg::ST_RUN;
            end
            bcrm_pkg::ST_RUN: begin
                ctrl.step = 1'b1;
                bit_next  = bit_reg + bcrm_pkg::BIT_CNT_W'(1);
                if (bit_reg == bcrm_pkg::BIT_CNT_W'(VW - 1)) begin
                    state_next = bcrm_pkg::ST_FINISH;
                end
            end
            bcrm_pkg::ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    post       = 1'b1;
                    state_next = bcrm_pkg::ST_IDLE;
                end
            end
            default: state_next = bcrm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        for (int k = 0; k < WINDOW_DEPTH; k++) begin
            valid_mask[k] = (CNT_W'(k) < fill_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == bcrm_pkg::ST_LOAD) begin
            for (int q = 0; q < NQ; q++) begin
                for (int k = 0; k < WINDOW_DEPTH; k++) begin
                    work_reg[q][k] <= store_reg[q][k];
                end
            end
        end else if (ctrl.step) begin
            for (int q = 0; q < NQ; q++) begin
                for (int k = 0; k < WINDOW_DEPTH; k++) begin
                    work_reg[q][k] <= {work_reg[q][k][VW-2:0], 1'b0};
                end
            end
        end
    end

    assign rank_lo = (fill_reg - CNT_W'(1)) >> 1;
    assign rank_hi = fill_reg >> 1;

    for (genvar q = 0; q < NQ; q++) begin : g_q
        logic [WINDOW_DEPTH-1:0] msb;
        for (genvar k = 0; k < WINDOW_DEPTH; k++) begin : g_k
            assign msb[k] = work_reg[q][k][VW-1];
        end

        bcrm_select #(.WINDOW_DEPTH(WINDOW_DEPTH), .CNT_W(CNT_W)) u_lo (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .rank_init  (rank_lo),
            .valid_mask (valid_mask),
            .bits       (msb),
            .result     (sel_lo[q])
        );

        bcrm_select #(.WINDOW_DEPTH(WINDOW_DEPTH), .CNT_W(CNT_W)) u_hi (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .rank_init  (rank_hi),
            .valid_mask (valid_mask),
            .bits       (msb),
            .result     (sel_hi[q])
        );

        assign med[q] = bcrm_pkg::OUT_W'(signed'(sel_lo[q] ^ SIGN_FLIP))
                      + bcrm_pkg::OUT_W'(signed'(sel_hi[q] ^ SIGN_FLIP));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (post) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (post) begin
            for (int q = 0; q < NQ; q++) begin
                out_reg[q] <= med[q];
            end
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_bl_col = out_reg[bcrm_pkg::Q_LEFT];
    assign m_bl_row = out_reg[bcrm_pkg::Q_BOTTOM];
    assign m_br_col = out_reg[bcrm_pkg::Q_RIGHT];
    assign m_br_row = out_reg[bcrm_pkg::Q_BOTTOM];
    assign m_tr_col = out_reg[bcrm_pkg::Q_RIGHT];
    assign m_tr_row = out_reg[bcrm_pkg::Q_TOP];
    assign m_tl_col = out_reg[bcrm_pkg::Q_LEFT];
    assign m_tl_row = out_reg[bcrm_pkg::Q_TOP];

endmodule

@@ design/bcrm_checker.sv @@
// ----------------------------------------------------------------------------
// bcrm_checker
// Port-level checks for the box corner running median filter.
// ----------------------------------------------------------------------------
module bcrm_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              s_box_found,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic signed [bcrm_pkg::OUT_W-1:0] m_bl_col,
    input logic signed [bcrm_pkg::OUT_W-1:0] m_bl_row,
    input logic signed [bcrm_pkg::OUT_W-1:0] m_br_row,
    input logic signed [bcrm_pkg::OUT_W-1:0] m_tl_col
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_bl_col))
        else $error("result dropped or changed while stalled");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_box_found |=> !s_ready)
        else $error("request taken while a box is in work");

    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_box_found |=> s_ready)
        else $error("request without a box stalled the input");

    a_share: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_bl_col == m_tl_col) && (m_bl_row == m_br_row))
        else $error("shared corner medians differ");

endmodule

bind box_corner_running_median bcrm_checker u_bcrm_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_box_found (s_box_found),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_bl_col    (m_bl_col),
    .m_bl_row    (m_bl_row),
    .m_br_row    (m_br_row),
    .m_tl_col    (m_tl_col)
);
